// ===== rtl/core/bmp_rle_pkg.sv =====
// Shared types and constants of the bitmap RLE pixel decoder.
package bmp_rle_pkg;

    // Default image size limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_MAX    = (1 << CFG_DATA_W) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd2;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 24;
    localparam int COUNT_W  = 8;

    // Escape codes that follow a zero count byte
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_EOI   = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'h02;

    // A delta moves at most 255 columns, so the column wrap quotient fits in 8 bits
    localparam int WRAP_STEPS = 8;

    // One compressed byte with its start-of-image mark
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              image_start;
    } item_t;

    // One run descriptor
    typedef struct packed {
        logic [OFFSET_W-1:0] pixel_offset;
        logic [COUNT_W-1:0]  pixel_count;
        logic [BYTE_W-1:0]   first_index;
        logic [BYTE_W-1:0]   second_index;
        logic                image_done;
    } run_t;

endpackage

// ===== rtl/core/bmp_rle_pixel_decoder.sv =====
// Top level of the bitmap RLE8 / RLE4 run decoder.
//
// Compressed bytes enter on the in channel (data_byte, image_start marks the
// first byte of an image and clears the parse state). Each pixel-carrying byte,
// an end of image code, or a byte that fills the image gives one run descriptor
// on the out channel: pixel_offset, pixel_count, first_index, second_index and
// image_done. Count, escape, delta and pad bytes give nothing.
// The cfg channel writes image_width (index 0), the row count of the image
// (index 1) and four_bit_mode (index 2); it is always ready. The user must write it
// only while idle; the block itself does not enforce this. A byte waits in the input
// register and its result in the result register. Throughput: one byte per cycle
// while the result slot is free and the column wrap unit is idle. A delta that moves
// the column past the row end starts that unit, which works one quotient bit per
// cycle; the next byte waits for it. When out_ready is low, the held result stays and
// one more byte is buffered in the input register; then in_ready drops.
// Reset clears the parse state and sets width 1, height 1 and RLE8 mode.
module bmp_rle_pixel_decoder #(
    parameter int MAX_WIDTH  = bmp_rle_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmp_rle_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [bmp_rle_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                     image_start,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [bmp_rle_pkg::OFFSET_W-1:0]         pixel_offset,
    output logic [bmp_rle_pkg::COUNT_W-1:0]          pixel_count,
    output logic [bmp_rle_pkg::BYTE_W-1:0]           first_index,
    output logic [bmp_rle_pkg::BYTE_W-1:0]           second_index,
    output logic                                     image_done,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [bmp_rle_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bmp_rle_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Effective limits and the widths that follow from them
    localparam int EFF_MAX_W = (MAX_WIDTH < bmp_rle_pkg::CFG_MAX) ?
                               MAX_WIDTH : bmp_rle_pkg::CFG_MAX;
    localparam int EFF_MAX_H = (MAX_HEIGHT < bmp_rle_pkg::CFG_MAX) ?
                               MAX_HEIGHT : bmp_rle_pkg::CFG_MAX;
    localparam int WW  = $clog2(EFF_MAX_W + 1);
    localparam int HW  = $clog2(EFF_MAX_H + 1);
    localparam int TW  = $clog2(EFF_MAX_W * EFF_MAX_H + 1);
    localparam int PW  = $clog2(EFF_MAX_W * EFF_MAX_H + 256 * EFF_MAX_W + 256);
    localparam int CW  = $clog2(EFF_MAX_W + 256);
    localparam int PRW = WW + bmp_rle_pkg::BYTE_W;

    logic [WW-1:0]      width;
    logic [TW-1:0]      total;
    logic               four_bit_mode;
    logic               take;
    logic               item_valid;
    bmp_rle_pkg::item_t item;
    logic [PRW-1:0]     prod;
    logic               slot_free;
    logic               run_valid;
    bmp_rle_pkg::run_t  run;
    bmp_rle_pkg::run_t  out_run;
    logic               wrap_busy;
    logic               wrap_done;
    logic               wrap_start;
    logic [CW-1:0]      wrap_col;
    logic [CW-1:0]      wrap_col_in;

    bmp_rle_cfg #(
        .EFF_MAX_W (EFF_MAX_W),
        .EFF_MAX_H (EFF_MAX_H),
        .WW        (WW),
        .HW        (HW),
        .TW        (TW)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .width         (width),
        .total         (total),
        .four_bit_mode (four_bit_mode)
    );

    bmp_rle_in_reg #(
        .WW  (WW),
        .PRW (PRW)
    ) u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .image_start (image_start),
        .width       (width),
        .take        (take),
        .item_valid  (item_valid),
        .item        (item),
        .prod        (prod)
    );

    bmp_rle_wrap #(
        .WW (WW),
        .CW (CW)
    ) u_wrap (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (wrap_start),
        .col_in  (wrap_col_in),
        .width   (width),
        .busy    (wrap_busy),
        .done    (wrap_done),
        .col_out (wrap_col)
    );

    bmp_rle_parse #(
        .WW  (WW),
        .TW  (TW),
        .PW  (PW),
        .CW  (CW),
        .PRW (PRW)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .prod          (prod),
        .take          (take),
        .width         (width),
        .total         (total),
        .four_bit_mode (four_bit_mode),
        .slot_free     (slot_free),
        .run_valid     (run_valid),
        .run           (run),
        .wrap_busy     (wrap_busy),
        .wrap_done     (wrap_done),
        .wrap_col      (wrap_col),
        .wrap_start    (wrap_start),
        .wrap_col_in   (wrap_col_in)
    );

    bmp_rle_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && run_valid),
        .run       (run),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_run   (out_run)
    );

    // Break the descriptor out onto the ports
    assign pixel_offset = out_run.pixel_offset;
    assign pixel_count  = out_run.pixel_count;
    assign first_index  = out_run.first_index;
    assign second_index = out_run.second_index;
    assign image_done   = out_run.image_done;

endmodule

// ===== rtl/core/bmp_rle_cfg.sv =====
// Configuration registers: clamped image size, pixel total and nibble mode.
module bmp_rle_cfg #(
    parameter int EFF_MAX_W = bmp_rle_pkg::MAX_WIDTH_DEF,
    parameter int EFF_MAX_H = bmp_rle_pkg::MAX_HEIGHT_DEF,
    parameter int WW        = $clog2(EFF_MAX_W + 1),
    parameter int HW        = $clog2(EFF_MAX_H + 1),
    parameter int TW        = $clog2(EFF_MAX_W * EFF_MAX_H + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmp_rle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmp_rle_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [WW-1:0]                       width,
    output logic [TW-1:0]                       total,
    output logic                                four_bit_mode
);

    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [TW-1:0] total_reg;
    logic          mode_reg;
    logic [WW-1:0] width_clamp;
    logic [HW-1:0] height_clamp;
    logic          wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // Clamp the written value into 1..max
    always_comb
    begin
        if (cfg_data == '0)
        begin
            width_clamp  = WW'(1);
            height_clamp = HW'(1);
        end
        else
        begin
            if (cfg_data > bmp_rle_pkg::CFG_DATA_W'(EFF_MAX_W))
                width_clamp = WW'(EFF_MAX_W);
            else
                width_clamp = WW'(cfg_data);
            if (cfg_data > bmp_rle_pkg::CFG_DATA_W'(EFF_MAX_H))
                height_clamp = HW'(EFF_MAX_H);
            else
                height_clamp = HW'(cfg_data);
        end
    end

    // Update the addressed register on a transfer, and the pixel total on a size write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(1);
            height_reg <= HW'(1);
            total_reg  <= TW'(1);
            mode_reg   <= 1'b0;
        end
        else if (wr)
        begin
            case (cfg_index)
                bmp_rle_pkg::CFG_IDX_WIDTH:
                begin
                    width_reg <= width_clamp;
                    total_reg <= TW'(width_clamp) * TW'(height_reg);
                end
                bmp_rle_pkg::CFG_IDX_HEIGHT:
                begin
                    height_reg <= height_clamp;
                    total_reg  <= TW'(width_reg) * TW'(height_clamp);
                end
                bmp_rle_pkg::CFG_IDX_MODE:
                begin
                    mode_reg <= cfg_data[0];
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    assign width         = width_reg;
    assign total         = total_reg;
    assign four_bit_mode = mode_reg;

endmodule

// ===== rtl/core/bmp_rle_in_reg.sv =====
// Input register: holds one compressed byte and its product with the row width.
module bmp_rle_in_reg #(
    parameter int WW  = $clog2(bmp_rle_pkg::MAX_WIDTH_DEF + 1),
    parameter int PRW = WW + bmp_rle_pkg::BYTE_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bmp_rle_pkg::BYTE_W-1:0]    data_byte,
    input  logic                              image_start,
    input  logic [WW-1:0]                     width,
    input  logic                              take,
    output logic                              item_valid,
    output bmp_rle_pkg::item_t                item,
    output logic [PRW-1:0]                    prod
);

    logic               valid_reg;
    bmp_rle_pkg::item_t item_reg;
    logic [PRW-1:0]     prod_reg;
    logic               load;

    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // Capture the byte and the delta row product
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte   <= data_byte;
            item_reg.image_start <= image_start;
            prod_reg             <= PRW'(data_byte) * PRW'(width);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign prod       = prod_reg;

endmodule

// ===== rtl/core/bmp_rle_wrap.sv =====
// Column wrap unit: folds a column past the row end back into 1..width, one bit a cycle.
module bmp_rle_wrap #(
    parameter int WW = $clog2(bmp_rle_pkg::MAX_WIDTH_DEF + 1),
    parameter int CW = $clog2(bmp_rle_pkg::MAX_WIDTH_DEF + 256)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] col_in,
    input  logic [WW-1:0] width,
    output logic          busy,
    output logic          done,
    output logic [CW-1:0] col_out
);

    localparam int SW  = WW + bmp_rle_pkg::WRAP_STEPS;
    localparam int SCW = $clog2(bmp_rle_pkg::WRAP_STEPS);

    logic           busy_reg;
    logic [SCW-1:0] step_reg;
    logic [CW-1:0]  rem_reg;
    logic [SW-1:0]  shifted;
    logic [CW-1:0]  rem_next;

    // One restoring division step
    always_comb
    begin
        shifted = SW'(width) << step_reg;
        if (SW'(rem_reg) >= shifted)
            rem_next = rem_reg - CW'(shifted);
        else
            rem_next = rem_reg;
    end

    // Sequence the steps from the top quotient bit down
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= SCW'(bmp_rle_pkg::WRAP_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - SCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            rem_reg <= col_in - CW'(1);
        else if (busy_reg)
            rem_reg <= rem_next;
    end

    assign busy    = busy_reg;
    assign done    = busy_reg && (step_reg == '0);
    assign col_out = rem_next + CW'(1);

endmodule

// ===== rtl/core/bmp_rle_parse.sv =====
// Parser: escape tracking, run clipping and position state, one byte per transfer.
module bmp_rle_parse #(
    parameter int WW  = $clog2(bmp_rle_pkg::MAX_WIDTH_DEF + 1),
    parameter int TW  = $clog2(bmp_rle_pkg::MAX_WIDTH_DEF * bmp_rle_pkg::MAX_HEIGHT_DEF + 1),
    parameter int PW  = TW + 1,
    parameter int CW  = $clog2(bmp_rle_pkg::MAX_WIDTH_DEF + 256),
    parameter int PRW = WW + bmp_rle_pkg::BYTE_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  bmp_rle_pkg::item_t item,
    input  logic [PRW-1:0]     prod,
    output logic               take,
    input  logic [WW-1:0]      width,
    input  logic [TW-1:0]      total,
    input  logic               four_bit_mode,
    input  logic               slot_free,
    output logic               run_valid,
    output bmp_rle_pkg::run_t  run,
    input  logic               wrap_busy,
    input  logic               wrap_done,
    input  logic [CW-1:0]      wrap_col,
    output logic               wrap_start,
    output logic [CW-1:0]      wrap_col_in
);

    // Parse phases
    localparam logic [2:0] PH_COUNT = 3'd0;
    localparam logic [2:0] PH_VALUE = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_DX    = 3'd3;
    localparam logic [2:0] PH_DY    = 3'd4;
    localparam logic [2:0] PH_ABS   = 3'd5;
    localparam logic [2:0] PH_PAD   = 3'd6;

    localparam int BW = bmp_rle_pkg::BYTE_W;

    logic [2:0]    phase_reg, phase_next;
    logic [BW-1:0] pend_reg, pend_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] col_reg, col_next;
    logic [BW-1:0] abs_reg, abs_next;
    logic [BW-1:0] dx_reg, dx_next;
    logic          fin_reg, fin_next;

    logic [2:0]    st_phase;
    logic [BW-1:0] st_pend;
    logic [PW-1:0] st_pos;
    logic [CW-1:0] st_col;
    logic [BW-1:0] st_abs;
    logic [BW-1:0] st_dx;
    logic          st_fin;

    logic [BW-1:0] byte_in;
    logic [BW-1:0] hi;
    logic [BW-1:0] lo;
    logic          fire;

    logic [PW-1:0] img_room;
    logic [CW-1:0] row_room;
    logic [BW-1:0] row_cnt;
    logic [BW-1:0] val_cnt;
    logic [BW-1:0] abs_left;
    logic [BW-1:0] take_cnt;
    logic [BW-1:0] abs_cnt;
    logic [BW-1:0] abs_new;
    logic [BW:0]   abs_bytes;
    logic [BW-1:0] adv_cnt;
    logic [PW-1:0] pos_adv;
    logic [CW-1:0] col_sum;
    logic [CW-1:0] col_w1;
    logic [CW-1:0] col_abs;
    logic [PW-1:0] eol_pos;
    logic [PW-1:0] dy_pos;
    logic [CW-1:0] col_dy;
    logic [PW-1:0] cand_pos;
    logic          full;

    assign fire    = item_valid && !wrap_busy && slot_free;
    assign take    = fire;
    assign byte_in = item.data_byte;
    assign hi      = four_bit_mode ? {4'h0, byte_in[7:4]} : byte_in;
    assign lo      = four_bit_mode ? {4'h0, byte_in[3:0]} : byte_in;

    // Start of image clears the state seen by this byte
    assign st_phase = item.image_start ? PH_COUNT : phase_reg;
    assign st_pend  = item.image_start ? '0 : pend_reg;
    assign st_pos   = item.image_start ? '0 : pos_reg;
    assign st_col   = item.image_start ? '0 : col_reg;
    assign st_abs   = item.image_start ? '0 : abs_reg;
    assign st_dx    = item.image_start ? '0 : dx_reg;
    assign st_fin   = item.image_start ? 1'b0 : fin_reg;

    // Clip an encoded run at the row end and the image end
    assign img_room = PW'(total) - st_pos;
    assign row_room = (st_col < CW'(width)) ? CW'(width) - st_col : '0;
    assign row_cnt  = (row_room < CW'(st_pend)) ? row_room[BW-1:0] : st_pend;
    assign val_cnt  = (img_room < PW'(row_cnt)) ? img_room[BW-1:0] : row_cnt;

    // Literal pixels of an absolute run: two per byte in nibble mode, one in the last byte of an odd count
    assign abs_left  = st_pend - st_abs;
    assign take_cnt  = (four_bit_mode && (abs_left >= BW'(2))) ? BW'(2) : BW'(1);
    assign abs_cnt   = (img_room < PW'(take_cnt)) ? img_room[BW-1:0] : take_cnt;
    assign abs_new   = st_abs + take_cnt;
    assign abs_bytes = four_bit_mode ? (({1'b0, st_pend} + (BW+1)'(1)) >> 1)
                                     : {1'b0, st_pend};

    // Advance position and column; wrap an absolute run into the next rows
    assign adv_cnt = (st_phase == PH_ABS) ? abs_cnt : val_cnt;
    assign pos_adv = st_pos + PW'(adv_cnt);
    assign col_sum = st_col + CW'(adv_cnt);
    assign col_w1  = col_sum - CW'(width);
    assign col_abs = (col_sum > CW'(width)) ?
                     ((col_w1 > CW'(width)) ? col_w1 - CW'(width) : col_w1) : col_sum;

    // End of line and delta moves
    assign eol_pos = st_pos - PW'(st_col) + PW'(width);
    assign dy_pos  = st_pos + PW'(st_dx) + PW'(prod);
    assign col_dy  = st_col + CW'(st_dx);

    // Select the position to check against the image end
    always_comb
    begin
        case (st_phase)
            PH_VALUE: cand_pos = pos_adv;
            PH_ABS:   cand_pos = pos_adv;
            PH_ESC:   cand_pos = eol_pos;
            PH_DY:    cand_pos = dy_pos;
            default:  cand_pos = st_pos;
        endcase
    end

    assign full = cand_pos >= PW'(total);

    // Next state and run descriptor
    always_comb
    begin
        phase_next  = st_phase;
        pend_next   = st_pend;
        pos_next    = st_pos;
        col_next    = st_col;
        abs_next    = st_abs;
        dx_next     = st_dx;
        fin_next    = st_fin;
        run_valid   = 1'b0;
        wrap_start  = 1'b0;
        run.pixel_offset = bmp_rle_pkg::OFFSET_W'(st_pos);
        run.pixel_count  = '0;
        run.first_index  = '0;
        run.second_index = '0;
        run.image_done   = 1'b0;

        if (!st_fin)
        begin
            case (st_phase)
                PH_COUNT:
                begin
                    if (byte_in != '0)
                    begin
                        pend_next  = byte_in;
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        phase_next = PH_ESC;
                    end
                end
                PH_VALUE:
                begin
                    col_next         = col_sum;
                    pos_next         = full ? PW'(total) : cand_pos;
                    fin_next         = full;
                    phase_next       = PH_COUNT;
                    run_valid        = 1'b1;
                    run.pixel_count  = val_cnt;
                    run.first_index  = hi;
                    run.second_index = lo;
                    run.image_done   = full;
                end
                PH_ESC:
                begin
                    if (byte_in == bmp_rle_pkg::ESC_EOL)
                    begin
                        col_next         = '0;
                        phase_next       = PH_COUNT;
                        pos_next         = full ? PW'(total) : cand_pos;
                        fin_next         = full;
                        run_valid        = full;
                        run.pixel_offset = bmp_rle_pkg::OFFSET_W'(total);
                        run.image_done   = 1'b1;
                    end
                    else if (byte_in == bmp_rle_pkg::ESC_EOI)
                    begin
                        fin_next       = 1'b1;
                        phase_next     = PH_COUNT;
                        run_valid      = 1'b1;
                        run.image_done = 1'b1;
                    end
                    else if (byte_in == bmp_rle_pkg::ESC_DELTA)
                    begin
                        phase_next = PH_DX;
                    end
                    else
                    begin
                        pend_next  = byte_in;
                        abs_next   = '0;
                        phase_next = PH_ABS;
                    end
                end
                PH_DX:
                begin
                    dx_next    = byte_in;
                    phase_next = PH_DY;
                end
                PH_DY:
                begin
                    col_next         = col_dy;
                    phase_next       = PH_COUNT;
                    pos_next         = full ? PW'(total) : cand_pos;
                    fin_next         = full;
                    run_valid        = full;
                    run.pixel_offset = bmp_rle_pkg::OFFSET_W'(total);
                    run.image_done   = 1'b1;
                    wrap_start       = fire && !full && (col_dy > CW'(width));
                end
                PH_ABS:
                begin
                    abs_next = abs_new;
                    col_next = col_abs;
                    pos_next = full ? PW'(total) : cand_pos;
                    fin_next = full;
                    if (abs_new >= st_pend)
                        phase_next = abs_bytes[0] ? PH_PAD : PH_COUNT;
                    run_valid        = 1'b1;
                    run.pixel_count  = abs_cnt;
                    run.first_index  = hi;
                    run.second_index = lo;
                    run.image_done   = full;
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

    assign wrap_col_in = col_dy;

    // Commit the state on a transfer; take the folded column from the wrap unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COUNT;
            pend_reg  <= '0;
            pos_reg   <= '0;
            col_reg   <= '0;
            abs_reg   <= '0;
            dx_reg    <= '0;
            fin_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            abs_reg   <= abs_next;
            dx_reg    <= dx_next;
            fin_reg   <= fin_next;
        end
        else if (wrap_done)
        begin
            col_reg <= wrap_col;
        end
    end

endmodule

// ===== rtl/core/bmp_rle_out_reg.sv =====
// Result register: holds one run descriptor until the receiver takes it.
module bmp_rle_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bmp_rle_pkg::run_t run,
    output logic              slot_free,
    output logic              out_valid,
    input  logic              out_ready,
    output bmp_rle_pkg::run_t out_run
);

    logic              valid_reg;
    bmp_rle_pkg::run_t run_reg;

    assign slot_free = !valid_reg || out_ready;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (slot_free)
            valid_reg <= load;
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (slot_free && load)
            run_reg <= run;
    end

    assign out_valid = valid_reg;
    assign out_run   = run_reg;

endmodule

// ===== bench/bmp_rle_pixel_decoder_tb.sv =====
// Self-checking testbench for the bitmap RLE8 / RLE4 run decoder.
`timescale 1ns / 1ps

module bmp_rle_pixel_decoder_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int REPORT_LIMIT   = 10;

    typedef enum logic [2:0] {
        ST_COUNT,
        ST_RUN_VALUE,
        ST_ESCAPE,
        ST_DELTA_X,
        ST_DELTA_Y,
        ST_LITERAL,
        ST_PAD
    } parse_state_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic [bmp_rle_pkg::BYTE_W-1:0]      data_byte;
    logic                                image_start;
    logic                                out_valid;
    logic                                out_ready;
    logic [bmp_rle_pkg::OFFSET_W-1:0]    pixel_offset;
    logic [bmp_rle_pkg::COUNT_W-1:0]     pixel_count;
    logic [bmp_rle_pkg::BYTE_W-1:0]      first_index;
    logic [bmp_rle_pkg::BYTE_W-1:0]      second_index;
    logic                                image_done;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [bmp_rle_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [bmp_rle_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Decoder image settings as seen by the predictor
    logic [bmp_rle_pkg::CFG_DATA_W-1:0] reg_width    = 1;
    logic [bmp_rle_pkg::CFG_DATA_W-1:0] reg_height   = 1;
    logic                               reg_four_bit = 1'b0;

    // Predictor parse state
    parse_state_t    parse_state   = ST_COUNT;
    int unsigned     run_length    = 0;
    longint unsigned cursor        = 0;
    int unsigned     cursor_column = 0;
    int unsigned     literals_done = 0;
    int unsigned     skip_columns  = 0;
    bit              img_finished  = 1'b0;

    bmp_rle_pkg::run_t expected_runs[$];
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    int   bytes_used   = 0;
    int   in_gap_max   = 0;
    int   out_gap_max  = 0;
    bit   start_next   = 1'b0;

    bmp_rle_pixel_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .image_start  (image_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_offset (pixel_offset),
        .pixel_count  (pixel_count),
        .first_index  (first_index),
        .second_index (second_index),
        .image_done   (image_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Run predictor
    // ---------------------------------------------------------------

    function automatic int unsigned row_width();
        int unsigned w;
        w = reg_width;
        if (w < 1) w = 1;
        if (w > bmp_rle_pkg::MAX_WIDTH_DEF) w = bmp_rle_pkg::MAX_WIDTH_DEF;
        return w;
    endfunction

    function automatic longint unsigned image_pixels();
        longint unsigned h;
        h = reg_height;
        if (h < 1) h = 1;
        if (h > bmp_rle_pkg::MAX_HEIGHT_DEF) h = bmp_rle_pkg::MAX_HEIGHT_DEF;
        return h * row_width();
    endfunction

    // Cut a pixel count to the room left in the image
    function automatic int unsigned fit_image(input int unsigned n);
        longint unsigned room;
        room = (cursor < image_pixels()) ? image_pixels() - cursor : 0;
        return (n > room) ? int'(room) : n;
    endfunction

    // Pin the cursor at the image end once it is reached
    function automatic void mark_full();
        if (cursor >= image_pixels())
        begin
            cursor       = image_pixels();
            img_finished = 1'b1;
        end
    endfunction

    // Keep the column in 1..width after a move past the row end
    function automatic void wrap_cursor_column(input int unsigned w);
        if (cursor_column > w) cursor_column = ((cursor_column - 1) % w) + 1;
    endfunction

    function automatic bmp_rle_pkg::run_t make_run(input longint unsigned start,
                                                   input int unsigned n,
                                                   input logic [7:0] even_idx,
                                                   input logic [7:0] odd_idx);
        bmp_rle_pkg::run_t r;
        r.pixel_offset = start[bmp_rle_pkg::OFFSET_W-1:0];
        r.pixel_count  = n[bmp_rle_pkg::COUNT_W-1:0];
        r.first_index  = even_idx;
        r.second_index = odd_idx;
        r.image_done   = img_finished;
        return r;
    endfunction

    // Advance the parse state by one byte; return 1 when a run descriptor results
    function automatic bit decode_byte(input logic [7:0] value, input logic fresh,
                                       output bmp_rle_pkg::run_t r);
        int unsigned     w;
        int unsigned     n;
        int unsigned     take;
        int unsigned     nbytes;
        longint unsigned start;
        logic [7:0]      even_idx;
        logic [7:0]      odd_idx;
        r = '0;
        if (fresh)
        begin
            parse_state   = ST_COUNT;
            run_length    = 0;
            cursor        = 0;
            cursor_column = 0;
            literals_done = 0;
            skip_columns  = 0;
            img_finished  = 1'b0;
        end
        if (img_finished) return 1'b0;
        w        = row_width();
        even_idx = reg_four_bit ? {4'h0, value[7:4]} : value;
        odd_idx  = reg_four_bit ? {4'h0, value[3:0]} : value;
        case (parse_state)
            ST_COUNT:
            begin
                if (value != 0)
                begin
                    run_length  = value;
                    parse_state = ST_RUN_VALUE;
                end
                else
                begin
                    parse_state = ST_ESCAPE;
                end
                return 1'b0;
            end
            ST_RUN_VALUE:
            begin
                n = (cursor_column < w) ? w - cursor_column : 0;
                if (n > run_length) n = run_length;
                n = fit_image(n);
                start = cursor;
                cursor += n;
                cursor_column += n;
                mark_full();
                parse_state = ST_COUNT;
                r = make_run(start, n, even_idx, odd_idx);
                return 1'b1;
            end
            ST_ESCAPE:
            begin
                if (value == bmp_rle_pkg::ESC_EOL)
                begin
                    cursor        = cursor - cursor_column + w;
                    cursor_column = 0;
                    parse_state   = ST_COUNT;
                    mark_full();
                    r = make_run(cursor, 0, 8'h00, 8'h00);
                    return img_finished;
                end
                if (value == bmp_rle_pkg::ESC_EOI)
                begin
                    img_finished = 1'b1;
                    parse_state  = ST_COUNT;
                    r = make_run(cursor, 0, 8'h00, 8'h00);
                    return 1'b1;
                end
                if (value == bmp_rle_pkg::ESC_DELTA)
                begin
                    parse_state = ST_DELTA_X;
                    return 1'b0;
                end
                run_length    = value;
                literals_done = 0;
                parse_state   = ST_LITERAL;
                return 1'b0;
            end
            ST_DELTA_X:
            begin
                skip_columns = value;
                parse_state  = ST_DELTA_Y;
                return 1'b0;
            end
            ST_DELTA_Y:
            begin
                cursor += longint'(skip_columns) + longint'(value) * w;
                cursor_column += skip_columns;
                wrap_cursor_column(w);
                parse_state = ST_COUNT;
                mark_full();
                r = make_run(cursor, 0, 8'h00, 8'h00);
                return img_finished;
            end
            ST_LITERAL:
            begin
                take = (reg_four_bit && (run_length - literals_done >= 2)) ? 2 : 1;
                literals_done += take;
                n = fit_image(take);
                start = cursor;
                cursor += n;
                cursor_column += n;
                wrap_cursor_column(w);
                mark_full();
                if (literals_done >= run_length)
                begin
                    nbytes = reg_four_bit ? (run_length + 1) >> 1 : run_length;
                    parse_state = nbytes[0] ? ST_PAD : ST_COUNT;
                end
                r = make_run(start, n, even_idx, odd_idx);
                return 1'b1;
            end
            default:
            begin
                parse_state = ST_COUNT;
                return 1'b0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Monitor: check results, predict accepted bytes, track settings
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        bmp_rle_pkg::run_t got;
        bmp_rle_pkg::run_t want;
        bmp_rle_pkg::run_t predicted;
        if (rst_n)
        begin
            // Compare the result against the oldest expectation
            if (out_valid && out_ready)
            begin
                got.pixel_offset = pixel_offset;
                got.pixel_count  = pixel_count;
                got.first_index  = first_index;
                got.second_index = second_index;
                got.image_done   = image_done;
                if (expected_runs.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected run: offset %0d count %0d idx %0h/%0h done %0b",
                                 got.pixel_offset, got.pixel_count, got.first_index,
                                 got.second_index, got.image_done);
                    mismatches++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (got.pixel_offset !== want.pixel_offset
                            || got.pixel_count !== want.pixel_count
                            || got.first_index !== want.first_index
                            || got.second_index !== want.second_index
                            || got.image_done !== want.image_done)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("run mismatch: expected offset %0d count %0d idx %0h/%0h done %0b",
                                     want.pixel_offset, want.pixel_count, want.first_index,
                                     want.second_index, want.image_done);
                            $display("              got offset %0d count %0d idx %0h/%0h done %0b",
                                     got.pixel_offset, got.pixel_count, got.first_index,
                                     got.second_index, got.image_done);
                        end
                        mismatches++;
                    end
                end
            end
            // Predict the run for each accepted byte
            if (in_valid && in_ready)
            begin
                if (!img_finished || image_start) bytes_used++;
                if (decode_byte(data_byte, image_start, predicted))
                    expected_runs.push_back(predicted);
            end
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bmp_rle_pkg::CFG_IDX_WIDTH:  reg_width    = cfg_data;
                    bmp_rle_pkg::CFG_IDX_HEIGHT: reg_height   = cfg_data;
                    bmp_rle_pkg::CFG_IDX_MODE:   reg_four_bit = cfg_data[0];
                    default: ;
                endcase
            end
            // Watchdog on cycles without any transfer
            if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result receiver: random stall before each transfer
    // ---------------------------------------------------------------

    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, out_gap_max);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Send one compressed byte; returns at the falling edge after its transfer
    // with valid still high, so the next call may follow without a gap
    task automatic send_compressed(input logic [7:0] value, input logic fresh);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= value;
        image_start <= fresh;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Send a byte, marking it as the first of an image when one is due
    task automatic feed(input logic [7:0] value);
        send_compressed(value, start_next);
        start_next = 1'b0;
    endtask

    // Drop valid and wait until every expected run has arrived
    task automatic wait_for_runs();
        in_valid <= 1'b0;
        while (expected_runs.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three registers; call only while the decoder is idle
    task automatic write_settings(input int w, input int h, input bit four_bit);
        logic [bmp_rle_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [bmp_rle_pkg::CFG_DATA_W-1:0] val [3];
        idx = '{bmp_rle_pkg::CFG_IDX_WIDTH, bmp_rle_pkg::CFG_IDX_HEIGHT,
                bmp_rle_pkg::CFG_IDX_MODE};
        val = '{w[bmp_rle_pkg::CFG_DATA_W-1:0], h[bmp_rle_pkg::CFG_DATA_W-1:0],
                {{(bmp_rle_pkg::CFG_DATA_W-1){1'b0}}, four_bit}};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gap();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 10;
        endcase
    endfunction

    // One well-formed code group with random content, or a bit of noise
    task automatic random_group(input bit deep_rows);
        int unsigned pick;
        int unsigned n;
        int unsigned nbytes;
        if (img_finished || $urandom_range(0, 99) == 0) start_next = 1'b1;
        pick = $urandom_range(0, 99);
        if (deep_rows && $urandom_range(0, 1) == 1)
        begin
            // Delta with a large row step to reach the far end of the image
            feed(8'h00);
            feed(bmp_rle_pkg::ESC_DELTA);
            feed(8'($urandom_range(0, 255)));
            feed(8'($urandom_range(150, 255)));
        end
        else if (pick < 40)
        begin
            // Encoded run
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
            feed(8'(n));
            feed(8'($urandom));
        end
        else if (pick < 60)
        begin
            // Absolute run, sometimes cut short
            n = ($urandom_range(0, 14) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 10);
            nbytes = reg_four_bit ? (n + 1) / 2 : n;
            feed(8'h00);
            feed(8'(n));
            if ($urandom_range(0, 19) == 0) nbytes = $urandom_range(0, nbytes - 1);
            else if (nbytes % 2 == 1) nbytes++;
            repeat (nbytes) feed(8'($urandom));
        end
        else if (pick < 70)
        begin
            feed(8'h00);
            feed(bmp_rle_pkg::ESC_EOL);
        end
        else if (pick < 82)
        begin
            feed(8'h00);
            feed(bmp_rle_pkg::ESC_DELTA);
            feed(8'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 4)));
            feed(8'($urandom_range(0, 3)));
        end
        else if (pick < 85)
        begin
            feed(8'h00);
            feed(bmp_rle_pkg::ESC_EOI);
        end
        else
        begin
            if ($urandom_range(0, 9) == 0) start_next = 1'b1;
            feed(8'($urandom));
        end
    endtask

    // One phase of random images at fixed settings
    task automatic random_images(input int w, input int h, input bit four_bit,
                                 input int n, input bit deep_rows);
        int goal;
        wait_for_runs();
        write_settings(w, h, four_bit);
        in_gap_max  = pick_gap();
        out_gap_max = pick_gap();
        start_next  = 1'b1;
        goal = bytes_used + n;
        while (bytes_used < goal) random_group(deep_rows);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // RLE8: runs clipped at the row end, a run at the row end, end of line,
    // delta, end of image, then a byte that is ignored
    task automatic test_rle8_escapes();
        logic [7:0] seq [$];
        wait_for_runs();
        write_settings(4, 2, 1'b0);
        in_gap_max  = 10;
        out_gap_max = 10;
        seq = '{8'd3, 8'hAB, 8'd5, 8'h00, 8'd1, 8'hFF, 8'h00, bmp_rle_pkg::ESC_EOL,
                8'h00, bmp_rle_pkg::ESC_DELTA, 8'd1, 8'd0, 8'h00, bmp_rle_pkg::ESC_EOI,
                8'h80};
        start_next = 1'b1;
        foreach (seq[i]) feed(seq[i]);
    endtask

    // RLE4: absolute runs with an odd nibble count, padding and column wrap,
    // then a run that fills the image
    task automatic test_rle4_literals();
        logic [7:0] seq [$];
        wait_for_runs();
        write_settings(3, 3, 1'b1);
        in_gap_max  = 0;
        out_gap_max = 3;
        seq = '{8'h00, 8'd3, 8'h12, 8'h30, 8'h00, 8'd5, 8'hAB, 8'hCD, 8'hEF, 8'h00,
                8'd4, 8'hF0, 8'h55};
        start_next = 1'b1;
        foreach (seq[i]) feed(seq[i]);
    endtask

    // Random streams over small and medium images in both modes
    task automatic test_random_streams();
        random_images(1, 1, 1'b0, 60, 1'b0);
        for (int i = 0; i < 5; i++)
            random_images($urandom_range(1, 20), $urandom_range(1, 20),
                          $urandom_range(0, 1), 80, 1'b0);
        random_images($urandom_range(20, 300), $urandom_range(2, 40),
                      $urandom_range(0, 1), 150, 1'b0);
    endtask

    // Size registers at and past their limits
    task automatic test_size_limits();
        random_images(0, 0, 1'b1, 60, 1'b0);
        random_images(8191, 8191, 1'b0, 250, 1'b1);
        random_images(4096, 4096, 1'b1, 250, 1'b1);
        random_images(4096, 1, 1'b0, 60, 1'b0);
        random_images(1, 4096, 1'b1, 60, 1'b1);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        image_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = bmp_rle_pkg::CFG_IDX_WIDTH;
        cfg_data    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_rle8_escapes();
        test_rle4_literals();
        test_random_streams();
        test_size_limits();

        wait_for_runs();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
